[hw/rtl/vopt_pkg.sv]
// shared types, option codes and defaults for the vendor option tlv parser
`timescale 1ns / 1ps
package vopt_pkg;

  localparam int unsigned DataWidth    = 8;
  localparam int unsigned OutDataWidth = 200;
  localparam int unsigned BufDepth     = 16;

  localparam logic [7:0] OPT_V4_FLAG = 8'd1;
  localparam logic [7:0] OPT_V4_ADDR = 8'd2;
  localparam logic [7:0] OPT_V4_PORT = 8'd3;
  localparam logic [7:0] OPT_V6_FLAG = 8'd4;
  localparam logic [7:0] OPT_V6_ADDR = 8'd5;
  localparam logic [7:0] OPT_V6_PORT = 8'd6;

  localparam logic [15:0] DEF_V6_PORT = 16'd8123;
  localparam logic [63:0] DEF_V6_HIGH = 64'hff02_0000_0000_0000;
  localparam logic [63:0] DEF_V6_LOW  = 64'h0000_0000_0000_0001;

  typedef enum logic [2:0] {
    PH_TYPE  = 3'b001,
    PH_LEN   = 3'b010,
    PH_VALUE = 3'b100
  } vopt_phase_t;

  typedef struct packed {
    logic                 last;
    logic [DataWidth-1:0] data;
  } vopt_item_t;

  typedef struct packed {
    logic        parse_ok;
    logic        announce_v4;
    logic [31:0] addr_v4;
    logic [15:0] port_v4;
    logic        announce_v6;
    logic [63:0] addr_v6_high;
    logic [63:0] addr_v6_low;
    logic [15:0] port_v6;
    logic        unknown_seen;
  } vopt_result_t;

  // exact value length of a known option, zero for an unknown one
  function automatic logic [4:0] needed_length(input logic [7:0] opt);
    logic [4:0] len;
    case (opt)
      OPT_V4_FLAG: len = 5'd1;
      OPT_V4_ADDR: len = 5'd4;
      OPT_V4_PORT: len = 5'd2;
      OPT_V6_FLAG: len = 5'd1;
      OPT_V6_ADDR: len = 5'd16;
      OPT_V6_PORT: len = 5'd2;
      default:     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[hw/rtl/vendor_option_tlv_parser_unit.sv]
// top level of the vendor option tlv parser
`timescale 1ns / 1ps
// usage:
// the slave channel takes one byte of a decoded type-length-value option
// message per request, with s_tlast high on the final byte of the message.
// the master channel gives one result per message, on its final byte only.
// one byte is taken every cycle unless a final byte waits for room; the
// input register feeds the parse logic, which writes the output register,
// so a result shows on m_tvalid once its final byte has passed both.
// while a result waits in the output register, bytes that are not final
// keep flowing; a final byte waits in the input register until the result
// ahead of it is taken, and s_tready then drops.
// reset clears both stages and restores the defaults: ipv4 off, ipv6 on,
// ff02::1 and port 8123. the defaults come back after every final byte.
// errors (wrong length, truncated value) freeze parsing for the rest of the
// message; fields completed before the error are still reported.
module vendor_option_tlv_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte[7:0]
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata    // parse_ok, announce_v4, addr_v4[31:0], port_v4[15:0],
                                  // announce_v6, addr_v6_high[63:0], addr_v6_low[63:0],
                                  // port_v6[15:0], unknown_seen, 4 zero bits
);
  import vopt_pkg::*;

  logic         item_valid;
  vopt_item_t   item;
  logic         take;
  logic         out_free;
  logic         res_valid;
  vopt_result_t res;

  vopt_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  vopt_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  vopt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

[hw/rtl/vopt_in_reg.sv]
// input register stage holding one request byte
`timescale 1ns / 1ps
module vopt_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [vopt_pkg::DataWidth-1:0] s_tdata,
  input  logic                      s_tlast,
  output logic                      item_valid,
  output vopt_pkg::vopt_item_t      item,
  input  logic                      take
);
  import vopt_pkg::*;

  logic held;

  assign s_tready   = !held || take;
  assign item_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data <= s_tdata;
      item.last <= s_tlast;
    end
  end

endmodule

[hw/rtl/vopt_core.sv]
// tlv parse state, value buffer and option fields
`timescale 1ns / 1ps
module vopt_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  vopt_pkg::vopt_item_t    item,
  input  logic                    out_free,
  output logic                    take,
  output logic                    res_valid,
  output vopt_pkg::vopt_result_t  res
);
  import vopt_pkg::*;

  vopt_phase_t phase, phase_next;
  logic [7:0]  current_type, current_type_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [3:0]  value_index, value_index_next;
  logic        error_seen, error_seen_next;
  logic        v4_flag, v4_flag_next;
  logic [31:0] v4_addr, v4_addr_next;
  logic [15:0] v4_port, v4_port_next;
  logic        v6_flag, v6_flag_next;
  logic [63:0] v6_high, v6_high_next;
  logic [63:0] v6_low, v6_low_next;
  logic [15:0] v6_port, v6_port_next;
  logic        unknown_flag, unknown_flag_next;

  logic [7:0] vbuf [BufDepth];
  logic [7:0] vbuf_m [BufDepth];
  logic [4:0] need;
  logic [7:0] b;
  logic       do_commit;
  logic       buf_wr;

  // a last byte needs room in the output register
  assign take = item_valid && (!item.last || out_free);
  assign b    = item.data;
  assign need = needed_length(current_type);

  // buffer as seen with the current value byte already in place
  always_comb begin
    for (int k = 0; k < BufDepth; k++) begin
      vbuf_m[k] = (value_index == 4'(k)) ? b : vbuf[k];
    end
  end

  always_comb begin
    phase_next        = phase;
    current_type_next = current_type;
    bytes_left_next   = bytes_left;
    value_index_next  = value_index;
    error_seen_next   = error_seen;
    do_commit         = 1'b0;
    buf_wr            = 1'b0;

    if (!error_seen) begin
      case (phase)
        PH_LEN: begin
          if (need != 5'd0 && b != {3'b000, need}) begin
            error_seen_next = 1'b1;
          end else if (b == 8'd0) begin
            do_commit  = 1'b1;
            phase_next = PH_TYPE;
          end else begin
            bytes_left_next  = b;
            value_index_next = 4'd0;
            phase_next       = PH_VALUE;
            if (item.last) error_seen_next = 1'b1;
          end
        end
        PH_VALUE: begin
          buf_wr           = (need != 5'd0);
          value_index_next = value_index + 4'd1;
          bytes_left_next  = bytes_left - 8'd1;
          if (bytes_left_next == 8'd0) begin
            do_commit  = 1'b1;
            phase_next = PH_TYPE;
          end else if (item.last) begin
            error_seen_next = 1'b1;
          end
        end
        default: begin
          current_type_next = b;
          phase_next        = PH_LEN;
        end
      endcase
    end

    v4_flag_next      = v4_flag;
    v4_addr_next      = v4_addr;
    v4_port_next      = v4_port;
    v6_flag_next      = v6_flag;
    v6_high_next      = v6_high;
    v6_low_next       = v6_low;
    v6_port_next      = v6_port;
    unknown_flag_next = unknown_flag;

    if (do_commit) begin
      case (current_type)
        OPT_V4_FLAG: v4_flag_next = (vbuf_m[0] != 8'd0);
        OPT_V4_ADDR: v4_addr_next = {vbuf_m[3], vbuf_m[2], vbuf_m[1], vbuf_m[0]};
        OPT_V4_PORT: v4_port_next = {vbuf_m[0], vbuf_m[1]};
        OPT_V6_FLAG: v6_flag_next = (vbuf_m[0] != 8'd0);
        OPT_V6_ADDR: begin
          v6_high_next = {vbuf_m[0], vbuf_m[1], vbuf_m[2], vbuf_m[3],
                          vbuf_m[4], vbuf_m[5], vbuf_m[6], vbuf_m[7]};
          v6_low_next  = {vbuf_m[8], vbuf_m[9], vbuf_m[10], vbuf_m[11],
                          vbuf_m[12], vbuf_m[13], vbuf_m[14], vbuf_m[15]};
        end
        OPT_V6_PORT: v6_port_next = {vbuf_m[0], vbuf_m[1]};
        default:     unknown_flag_next = 1'b1;
      endcase
    end
  end

  assign res_valid        = take && item.last;
  assign res.parse_ok     = !error_seen_next;
  assign res.announce_v4  = v4_flag_next;
  assign res.addr_v4      = v4_addr_next;
  assign res.port_v4      = v4_port_next;
  assign res.announce_v6  = v6_flag_next;
  assign res.addr_v6_high = v6_high_next;
  assign res.addr_v6_low  = v6_low_next;
  assign res.port_v6      = v6_port_next;
  assign res.unknown_seen = unknown_flag_next;

  always_ff @(posedge clk) begin
    if (rst || (take && item.last)) begin
      phase        <= PH_TYPE;
      current_type <= 8'd0;
      bytes_left   <= 8'd0;
      value_index  <= 4'd0;
      error_seen   <= 1'b0;
      v4_flag      <= 1'b0;
      v4_addr      <= 32'd0;
      v4_port      <= 16'd0;
      v6_flag      <= 1'b1;
      v6_high      <= DEF_V6_HIGH;
      v6_low       <= DEF_V6_LOW;
      v6_port      <= DEF_V6_PORT;
      unknown_flag <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      current_type <= current_type_next;
      bytes_left   <= bytes_left_next;
      value_index  <= value_index_next;
      error_seen   <= error_seen_next;
      v4_flag      <= v4_flag_next;
      v4_addr      <= v4_addr_next;
      v4_port      <= v4_port_next;
      v6_flag      <= v6_flag_next;
      v6_high      <= v6_high_next;
      v6_low       <= v6_low_next;
      v6_port      <= v6_port_next;
      unknown_flag <= unknown_flag_next;
    end
  end

  // a commit reads earlier bytes of the same option here, the current one via vbuf_m
  always_ff @(posedge clk) begin
    if (take && buf_wr) begin
      vbuf[value_index] <= b;
    end
  end

endmodule

[hw/rtl/vopt_out_reg.sv]
// output register for one parse result
`timescale 1ns / 1ps
module vopt_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    res_valid,
  input  vopt_pkg::vopt_result_t  res,
  output logic                    out_free,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [vopt_pkg::OutDataWidth-1:0] m_tdata
);
  import vopt_pkg::*;

  vopt_result_t held;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

  assign m_tdata = {4'b0000, held.unknown_seen, held.port_v6, held.addr_v6_low,
                    held.addr_v6_high, held.announce_v6, held.port_v4, held.addr_v4,
                    held.announce_v4, held.parse_ok};

endmodule
